FILE: src/jse_pkg.sv
`timescale 1ns / 1ps

package jse_pkg;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_DATA  = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 4;
  localparam int unsigned EscW  = 16;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  // one output run: up to two \uxxxx groups, an optional backslash,
  // then an optional trailing character
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [1:0]      n_esc;
    logic [EscW-1:0] hi;
    logic [EscW-1:0] lo;
    logic            pair;
    logic            tail;
    logic [7:0]      ch;
  } run_t;

  typedef struct packed {
    logic busy;
    logic free;
  } emit_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'h0, nib};
    end else begin
      r = 8'h57 + {4'h0, nib};
    end
    return r;
  endfunction

  // fills the escape part of a run from a code point
  function automatic run_t cp_run(input logic [CpW-1:0] cp);
    run_t r;
    logic [CpW-1:0] off;
    r   = '0;
    off = cp - 21'h10000;
    if (cp[20:16] != 5'd0) begin
      r.n_esc = 2'd2;
      r.hi    = 16'hD800 | {5'd0, off[20:10]};
      r.lo    = 16'hDC00 | {6'd0, off[9:0]};
    end else begin
      r.n_esc = 2'd1;
      r.hi    = cp[15:0];
    end
    return r;
  endfunction

  function automatic logic [LenW-1:0] esc_len(input logic [1:0] n_esc);
    logic [LenW-1:0] r;
    case (n_esc)
      2'd1:    r = 4'd6;
      2'd2:    r = 4'd12;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/json_string_escaper.sv
`timescale 1ns / 1ps

// streaming escaper for the body of a json string
// input channel: in_valid/in_stall with in_opcode (begin, data, end) and
//   in_data_byte; a request is taken when in_valid is high and in_stall low
// output channel: out_valid/out_stall with out_char and out_last_of_run,
//   which marks the final character caused by one input request
// config channel: cfg_valid/cfg_ready with cfg_data = utf8_escape; write it
//   only while no request is in flight
// path: a taken request is stored in the run register, and each of its
//   characters then passes through the output register
// throughput, while out_stall is low: one output character per cycle; a request
//   that turns into a single character (plain byte, quote) is taken every cycle, an
//   escape holds in_stall high while its run of 2, 6, 7, 12 or 13 characters
//   drains from the run register; requests that emit nothing load no run
// reset: synchronous on rst_n, clears the pending utf-8 sequence,
//   utf8_escape and both channels
// output stall: the output register holds; the next run waits in the run
//   register and a new request is taken only once that run has been handed
//   to the output register

module json_string_escaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import jse_pkg::*;

  // config and utf-8 decode state
  logic            utf8_escape_r;
  logic [CpW-1:0]  accum_r, accum_nxt;
  logic [1:0]      remaining_r, remaining_nxt;

  run_t            run;
  emit_stat_t      stat;
  logic            accept;
  logic            load;

  // always ready: the user must change config only while idle; not enforced here
  assign cfg_ready = 1'b1;

  // a request can enter whenever the run register is free this cycle
  assign in_stall = !stat.free;
  assign accept   = in_valid && !in_stall;
  // requests with no characters only update the decode state
  assign load     = accept && (run.len != '0);

  jse_decode u_decode (
    .opcode        (in_opcode),
    .data_byte     (in_data_byte),
    .utf8_escape   (utf8_escape_r),
    .accum         (accum_r),
    .remaining     (remaining_r),
    .run           (run),
    .accum_nxt     (accum_nxt),
    .remaining_nxt (remaining_nxt)
  );

  jse_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .run_in    (run),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_char  (out_char),
    .out_last  (out_last_of_run),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf8_escape_r <= 1'b0;
      accum_r       <= '0;
      remaining_r   <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        utf8_escape_r <= cfg_data;
      end
      if (accept) begin
        accum_r     <= accum_nxt;
        remaining_r <= remaining_nxt;
      end
    end
  end

  // gathered bits stay within what the pending byte count allows
  a_accum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((remaining_r == 2'd0) && (accum_r == '0)) ||
    ((remaining_r == 2'd1) && (accum_r[20:15] == '0)) ||
    ((remaining_r == 2'd2) && (accum_r[20:9] == '0)) ||
    ((remaining_r == 2'd3) && (accum_r[20:3] == '0)))
    else $error("utf-8 accumulator out of range for pending count");

  // begin and end markers drop any pending sequence
  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ((in_opcode == OP_BEGIN) || (in_opcode == OP_END)))
    |=> (remaining_r == 2'd0) && (accum_r == '0))
    else $error("sequence state survived a string marker");

  // no sequence starts while utf8_escape is clear
  a_no_seq_plain: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == OP_DATA) && (remaining_r == 2'd0) && !utf8_escape_r)
    |=> (remaining_r == 2'd0))
    else $error("utf-8 sequence opened with utf8_escape clear");

  // a stalled input means a run is still draining
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stat.busy)
    else $error("input stalled with no run in progress");

endmodule

FILE: src/jse_decode.sv
`timescale 1ns / 1ps

module jse_decode (
  input  logic [1:0]              opcode,
  input  logic [7:0]              data_byte,
  input  logic                    utf8_escape,
  input  logic [jse_pkg::CpW-1:0] accum,
  input  logic [1:0]              remaining,
  output jse_pkg::run_t           run,
  output logic [jse_pkg::CpW-1:0] accum_nxt,
  output logic [1:0]              remaining_nxt
);
  import jse_pkg::*;

  logic [CpW-1:0] shifted;
  run_t           r;

  assign shifted = {accum[CpW-7:0], data_byte[5:0]};

  always_comb begin
    r             = '0;
    accum_nxt     = accum;
    remaining_nxt = remaining;
    case (opcode_t'(opcode))
      OP_BEGIN: begin
        accum_nxt     = '0;
        remaining_nxt = 2'd0;
        r.tail        = 1'b1;
        r.ch          = CH_QUOTE;
      end
      OP_DATA: begin
        if (remaining != 2'd0) begin
          remaining_nxt = remaining - 2'd1;
          if (remaining == 2'd1) begin
            r         = cp_run(shifted);
            accum_nxt = '0;
          end else begin
            accum_nxt = shifted;
          end
        end else begin
          case (data_byte)
            8'h22: begin r.pair = 1'b1; r.tail = 1'b1; r.ch = CH_QUOTE;  end
            8'h5C: begin r.pair = 1'b1; r.tail = 1'b1; r.ch = CH_BSLASH; end
            8'h08: begin r.pair = 1'b1; r.tail = 1'b1; r.ch = 8'h62;     end
            8'h0C: begin r.pair = 1'b1; r.tail = 1'b1; r.ch = 8'h66;     end
            8'h0A: begin r.pair = 1'b1; r.tail = 1'b1; r.ch = 8'h6E;     end
            8'h0D: begin r.pair = 1'b1; r.tail = 1'b1; r.ch = 8'h72;     end
            8'h09: begin r.pair = 1'b1; r.tail = 1'b1; r.ch = 8'h74;     end
            default: begin
              if (data_byte < 8'h20) begin
                r.n_esc = 2'd1;
                r.hi    = {8'h00, data_byte};
              end else if (utf8_escape && data_byte[7]) begin
                // lead byte: sequence length from the top bits
                if (data_byte < 8'hE0) begin
                  accum_nxt     = {16'd0, data_byte[4:0]};
                  remaining_nxt = 2'd1;
                end else if (data_byte < 8'hF0) begin
                  accum_nxt     = {17'd0, data_byte[3:0]};
                  remaining_nxt = 2'd2;
                end else begin
                  accum_nxt     = {18'd0, data_byte[2:0]};
                  remaining_nxt = 2'd3;
                end
              end else begin
                r.tail = 1'b1;
                r.ch   = data_byte;
              end
            end
          endcase
        end
      end
      OP_END: begin
        if (remaining != 2'd0) begin
          r = cp_run(accum);
        end
        accum_nxt     = '0;
        remaining_nxt = 2'd0;
        r.tail        = 1'b1;
        r.ch          = CH_QUOTE;
      end
      default: begin
        r = '0;
      end
    endcase
    r.len = esc_len(r.n_esc) + {3'd0, r.pair} + {3'd0, r.tail};
    run   = r;
  end

endmodule

FILE: src/jse_emit.sv
`timescale 1ns / 1ps

module jse_emit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  jse_pkg::run_t          run_in,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [7:0]             out_char,
  output logic                   out_last,
  output jse_pkg::emit_stat_t    stat
);
  import jse_pkg::*;

  logic             busy_r, busy_nxt;
  run_t             run_r;
  logic [LenW-1:0]  idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r;
  logic             out_last_r;

  logic             emit;
  logic             at_last;
  logic             run_free;
  logic [LenW-1:0]  elen;
  logic             second;
  logic [LenW-1:0]  pos;
  logic [EscW-1:0]  val;
  logic [7:0]       ch;

  assign emit     = busy_r && (!out_valid_r || !out_stall);
  assign at_last  = (idx_r == run_r.len - 4'd1);
  assign run_free = !busy_r || (emit && at_last);

  // character at the current position of the run
  always_comb begin
    elen   = esc_len(run_r.n_esc);
    second = (idx_r >= 4'd6);
    pos    = second ? (idx_r - 4'd6) : idx_r;
    val    = second ? run_r.lo : run_r.hi;
    if (idx_r < elen) begin
      case (pos)
        4'd0:    ch = CH_BSLASH;
        4'd1:    ch = CH_U;
        4'd2:    ch = hex_char(val[15:12]);
        4'd3:    ch = hex_char(val[11:8]);
        4'd4:    ch = hex_char(val[7:4]);
        default: ch = hex_char(val[3:0]);
      endcase
    end else if (run_r.pair && (idx_r == elen)) begin
      ch = CH_BSLASH;
    end else begin
      ch = run_r.ch;
    end
  end

  always_comb begin
    busy_nxt      = run_free ? load : busy_r;
    idx_nxt       = load ? '0 : (emit ? idx_r + 4'd1 : idx_r);
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= run_in;
    end
    if (emit) begin
      out_char_r <= ch;
      out_last_r <= at_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign stat.busy = busy_r;
  assign stat.free = run_free;

endmodule
